// ----- sv/pfcm_pkg.sv -----
// Package: kinds, predicates, per-lane compare flags and predicate helper for the packed compare block.
package pfcm_pkg;

	typedef enum logic [1:0] {
		KIND_PS = 2'd0,
		KIND_PD = 2'd1,
		KIND_SD = 2'd2,
		KIND_SS = 2'd3
	} kind_t;

	localparam logic [7:0] PRED_EQ    = 8'd0;
	localparam logic [7:0] PRED_LT    = 8'd1;
	localparam logic [7:0] PRED_LE    = 8'd2;
	localparam logic [7:0] PRED_UNORD = 8'd3;
	localparam logic [7:0] PRED_NE    = 8'd4;
	localparam logic [7:0] PRED_GE    = 8'd5;
	localparam logic [7:0] PRED_GT    = 8'd6;
	localparam logic [7:0] PRED_ORD   = 8'd7;

	// Per-lane compare flags
	typedef struct packed {
		logic unord;
		logic eq;
		logic lt;
	} cmp_flags_t;

	function automatic logic apply_pred(input logic [7:0] pred, input cmp_flags_t f);
		logic r;
		r = 1'b0;
		if (f.unord) begin
			r = (pred == PRED_UNORD) || (pred == PRED_NE);
		end else begin
			case (pred)
				PRED_EQ:    r = f.eq;
				PRED_LT:    r = f.lt;
				PRED_LE:    r = f.lt | f.eq;
				PRED_UNORD: r = 1'b0;
				PRED_NE:    r = ~f.eq;
				PRED_GE:    r = ~f.lt;
				PRED_GT:    r = ~f.lt & ~f.eq;
				PRED_ORD:   r = 1'b1;
				default:    r = 1'b0;
			endcase
		end
		return r;
	endfunction

endpackage

// ----- sv/pfcm_lane.sv -----
// Module: compare flags for one 64-bit slot as one double or two singles.
module pfcm_lane (
	input  logic [63:0]              a,
	input  logic [63:0]              b,
	output pfcm_pkg::cmp_flags_t     dbl,
	output pfcm_pkg::cmp_flags_t     sgl_lo,
	output pfcm_pkg::cmp_flags_t     sgl_hi
);
	import pfcm_pkg::*;

	function automatic cmp_flags_t cmp_d(input logic [63:0] x, input logic [63:0] y);
		cmp_flags_t f;
		logic [63:0] kx, ky;
		f.unord = (x[62:0] > 63'h7FF0000000000000) || (y[62:0] > 63'h7FF0000000000000);
		kx = x[63] ? ~x : {1'b1, x[62:0]};
		ky = y[63] ? ~y : {1'b1, y[62:0]};
		if (x[62:0] == '0 && y[62:0] == '0) begin
			f.eq = 1'b1;
			f.lt = 1'b0;
		end else begin
			f.eq = kx == ky;
			f.lt = kx < ky;
		end
		return f;
	endfunction

	function automatic cmp_flags_t cmp_s(input logic [31:0] x, input logic [31:0] y);
		cmp_flags_t f;
		logic [31:0] kx, ky;
		f.unord = (x[30:0] > 31'h7F800000) || (y[30:0] > 31'h7F800000);
		kx = x[31] ? ~x : {1'b1, x[30:0]};
		ky = y[31] ? ~y : {1'b1, y[30:0]};
		if (x[30:0] == '0 && y[30:0] == '0) begin
			f.eq = 1'b1;
			f.lt = 1'b0;
		end else begin
			f.eq = kx == ky;
			f.lt = kx < ky;
		end
		return f;
	endfunction

	assign dbl    = cmp_d(a, b);
	assign sgl_lo = cmp_s(a[31:0], b[31:0]);
	assign sgl_hi = cmp_s(a[63:32], b[63:32]);
endmodule

// ----- sv/packed_float_compare_mask.sv -----
// Top level: packed/scalar IEEE compare producing per-lane all-ones masks.
// Pipeline: input reg (stage 1), then result reg (stage 2), then result valid.
// Throughput: one item per cycle; both stages advance whenever the result
// register is empty or being taken. A waiting result blocks input only once
// stage 1 also holds an item.
// Reset: arst_n clears only the stage valid bits; payload regs are not reset.
module packed_float_compare_mask (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  predicate,
	input  logic [63:0] dest_low,
	input  logic [63:0] dest_high,
	input  logic [63:0] source_low,
	input  logic [63:0] source_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_low,
	output logic [63:0] result_high
);
	import pfcm_pkg::*;

	// Stage 1: captured operands
	logic        vld_s1;
	kind_t       kind_s1;
	logic [7:0]  pred_s1;
	logic [63:0] dl_s1, dh_s1, sl_s1, sh_s1;
	// Stage 2: result register
	logic        vld_s2;
	logic [63:0] rl_s2, rh_s2;

	logic adv_s2;
	assign adv_s2   = ~vld_s2 | out_ready;
	// Stage 1 moves forward whenever stage 2 can take it
	assign in_ready = ~vld_s1 | adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) vld_s1 <= in_valid;
			if (adv_s2)   vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind_t'(kind);
			pred_s1 <= predicate;
			dl_s1   <= dest_low;
			dh_s1   <= dest_high;
			sl_s1   <= source_low;
			sh_s1   <= source_high;
		end
	end

	// Compare logic: low and high 64-bit slots
	cmp_flags_t lo_d, lo_s0, lo_s1f, hi_d, hi_s0, hi_s1f;

	pfcm_lane u_lane_lo (.a(dl_s1), .b(sl_s1), .dbl(lo_d), .sgl_lo(lo_s0), .sgl_hi(lo_s1f));
	pfcm_lane u_lane_hi (.a(dh_s1), .b(sh_s1), .dbl(hi_d), .sgl_lo(hi_s0), .sgl_hi(hi_s1f));

	logic m_lo_d, m_lo_0, m_lo_1, m_hi_d, m_hi_0, m_hi_1;
	assign m_lo_d = apply_pred(pred_s1, lo_d);
	assign m_lo_0 = apply_pred(pred_s1, lo_s0);
	assign m_lo_1 = apply_pred(pred_s1, lo_s1f);
	assign m_hi_d = apply_pred(pred_s1, hi_d);
	assign m_hi_0 = apply_pred(pred_s1, hi_s0);
	assign m_hi_1 = apply_pred(pred_s1, hi_s1f);

	logic [63:0] rl_d, rh_d;
	always_comb begin
		case (kind_s1)
			KIND_PS: begin
				rl_d = {{32{m_lo_1}}, {32{m_lo_0}}};
				rh_d = {{32{m_hi_1}}, {32{m_hi_0}}};
			end
			KIND_PD: begin
				rl_d = {64{m_lo_d}};
				rh_d = {64{m_hi_d}};
			end
			KIND_SD: begin
				// scalar: upper half of destination passes through
				rl_d = {64{m_lo_d}};
				rh_d = dh_s1;
			end
			default: begin
				rl_d = {dl_s1[63:32], {32{m_lo_0}}};
				rh_d = dh_s1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			rl_s2 <= rl_d;
			rh_s2 <= rh_d;
		end
	end

	assign out_valid   = vld_s2;
	assign result_low  = rl_s2;
	assign result_high = rh_s2;

	// A stalled result must hold
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_low) && $stable(result_high))
		else $error("result changed while stalled");
	// An accepted item appears at the result when out_ready is high at accept and while it sits in stage 1
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
		else $error("item not delivered");
	// Scalar kinds keep destination high bits
	a_scal: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv_s2 && (kind_s1 == KIND_SD || kind_s1 == KIND_SS)
		|=> result_high == $past(dh_s1))
		else $error("scalar upper bits altered");
endmodule
